// ===== src/priority_max_heap_defines.svh =====
// Assertion macros for the priority max-heap RTL.
// Included by modules that carry concurrent assertions.
`ifndef PRIORITY_MAX_HEAP_DEFINES_SVH
`define PRIORITY_MAX_HEAP_DEFINES_SVH
// property (plain condition or implication) checked on every edge outside reset
`define PMH_ASSERT_IMP(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// condition that must never be seen outside reset
`define PMH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== src/pmh_pkg.sv =====
// Package for the priority max-heap: entry type, action and status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmh_pkg;
	localparam int unsigned PrioW = 16;
	localparam int unsigned CodeW = 16;

	typedef struct packed {
		logic [PrioW-1:0] prio;
		logic [CodeW-1:0] code;
	} entry_t;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_RD,
		S_UP_CMP,
		S_POP_RD,
		S_POP_WR,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_DONE
	} state_t;

	function automatic logic ranks_higher(input entry_t a, input entry_t b);
		if (a.prio == b.prio) return a.code < b.code;
		return a.prio > b.prio;
	endfunction
endpackage
`default_nettype wire

// ===== src/pmh_if.sv =====
// Valid/ready channel interface for the priority max-heap.
// Payload type is a parameter so input and output channels share this file.
`timescale 1ns / 1ps
`default_nettype none
interface pmh_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/pmh_mem.sv =====
// Single-port-write, single-port-read heap store, registered read data.
// Depends on pmh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmh_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire pmh_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output pmh_pkg::entry_t      rdata
);
	pmh_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/priority_max_heap.sv =====
// Top level of the priority max-heap: sequencer around one heap store memory.
// Depends on pmh_pkg, pmh_if, pmh_mem and priority_max_heap_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_max_heap_defines.svh"
// Binary max-heap priority queue of up to CAPACITY {priority, code} entries held in
// one synchronous RAM (one write and one read per cycle, registered read data).
// Higher priority wins; on a tie the smaller code wins. One transaction is worked at
// a time. A push climbs while it outranks its parent, each step reading the parent,
// then comparing and moving it; a pop moves the last entry to the root and sinks it
// level by level, each level reading the left child, reading the right child, then
// comparing and moving; a peek reads the root; a dropped push, an empty pop or
// peek, or the unused action goes straight to the result.
// The result then waits in an output register; input ready returns once the result
// transaction is taken. The node being moved is kept in a register and written
// once at its final slot, so no forwarding is needed. A push on a full heap is
// dropped with status full; pop or peek on an empty heap returns status empty.
// No clearing pass: only data from slots below the count is ever used.
module priority_max_heap #(
	parameter int unsigned CAPACITY = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	pmh_if.sink      in_ch,
	pmh_if.source    out_ch
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = CW; // 1-based positions up to CAPACITY

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] entry_priority;
		logic [15:0] entry_code;
	} in_t;
	typedef struct packed {
		logic        has_entry;
		logic [15:0] out_priority;
		logic [15:0] out_code;
		logic        now_empty;
		logic [1:0]  op_status;
	} out_t;

	pmh_pkg::state_t state_q, state_n;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   pos_q;     // 1-based position of moving node
	pmh_pkg::entry_t node_q;    // moving node value
	pmh_pkg::entry_t left_q;    // left child during sift-down
	out_t            res_q;
	logic            res_valid_q;
	logic            is_pop_q;
	logic            node_wr_q; // node goes to pos_q in DONE

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	pmh_pkg::entry_t wdata, rdata;

	in_t             in_p;
	out_t            acc_res;
	logic            acc, push_ok, read_ok, busy, out_stall;
	logic [CW-1:0]   cnt_m1;
	logic [PW-1:0]   par, pos_m1, par_m1;
	logic [PW:0]     lc, lc_m1, rc;
	logic            up_swap, pop_down;
	logic            l_beats, r_ok, r_beats, dn_swap, dn_more;
	logic [PW-1:0]   best_sel;
	pmh_pkg::entry_t best_val;

	pmh_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign in_p = in_ch.payload;
	assign in_ch.ready = (state_q == pmh_pkg::S_IDLE) && !res_valid_q;
	assign out_ch.valid = res_valid_q;
	assign out_ch.payload = res_q;

	assign acc     = in_ch.valid && in_ch.ready;
	assign push_ok = in_p.action == pmh_pkg::ACT_PUSH && count_q < CW'(CAPACITY);
	assign read_ok = (in_p.action inside {pmh_pkg::ACT_POP, pmh_pkg::ACT_PEEK}) &&
		count_q != '0;
	assign cnt_m1  = count_q - CW'(1);

	// heap position arithmetic (1-based, slot = position - 1)
	assign par    = pos_q >> 1;
	assign pos_m1 = pos_q - PW'(1);
	assign par_m1 = par - PW'(1);
	assign lc     = {pos_q, 1'b0};
	assign lc_m1  = {pos_m1, 1'b1};
	assign rc     = {pos_q, 1'b1};

	// sift-up: parent is on rdata in UP_CMP
	assign up_swap = pmh_pkg::ranks_higher(node_q, rdata);
	// pop: keep sinking when the shrunk heap still has a left child under the root
	assign pop_down = count_q > CW'(2);

	// sift-down selection: left child held in left_q, right child on rdata in DN_CMP;
	// equal children keep the left one
	always_comb begin
		l_beats  = pmh_pkg::ranks_higher(left_q, node_q);
		r_ok     = rc <= {1'b0, count_q};
		r_beats  = r_ok && pmh_pkg::ranks_higher(rdata, l_beats ? left_q : node_q);
		dn_swap  = l_beats || r_beats;
		best_sel = r_beats ? rc[PW-1:0] : lc[PW-1:0];
		best_val = r_beats ? rdata : left_q;
		dn_more  = {best_sel, 1'b0} <= {1'b0, count_q};
	end

	// result fields known at acceptance
	always_comb begin
		acc_res = '0;
		if (in_p.action == pmh_pkg::ACT_PUSH && !push_ok)
			acc_res.op_status = pmh_pkg::ST_FULL;
		else if ((in_p.action inside {pmh_pkg::ACT_POP, pmh_pkg::ACT_PEEK}) && !read_ok)
			acc_res.op_status = pmh_pkg::ST_EMPTY;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pmh_pkg::S_IDLE: begin
				if (acc) begin
					if (push_ok)
						state_n = (count_q == '0) ? pmh_pkg::S_DONE : pmh_pkg::S_PUSH_RD;
					else if (read_ok)
						state_n = pmh_pkg::S_POP_RD;
					else
						state_n = pmh_pkg::S_DONE;
				end
			end
			pmh_pkg::S_PUSH_RD: state_n = pmh_pkg::S_UP_CMP;
			pmh_pkg::S_UP_CMP:
				state_n = (up_swap && par > PW'(1)) ? pmh_pkg::S_PUSH_RD : pmh_pkg::S_DONE;
			pmh_pkg::S_POP_RD: state_n = is_pop_q ? pmh_pkg::S_POP_WR : pmh_pkg::S_DONE;
			pmh_pkg::S_POP_WR: state_n = pop_down ? pmh_pkg::S_DN_RDL : pmh_pkg::S_DONE;
			pmh_pkg::S_DN_RDL: state_n = pmh_pkg::S_DN_RDR;
			pmh_pkg::S_DN_RDR: state_n = pmh_pkg::S_DN_CMP;
			pmh_pkg::S_DN_CMP:
				state_n = (dn_swap && dn_more) ? pmh_pkg::S_DN_RDL : pmh_pkg::S_DONE;
			pmh_pkg::S_DONE:   state_n = pmh_pkg::S_IDLE;
			default:           state_n = pmh_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		we = 1'b0;
		waddr = AW'(pos_m1);
		wdata = node_q;
		raddr = '0; // root, read while idle for pop/peek
		unique case (state_q)
			pmh_pkg::S_PUSH_RD: raddr = AW'(par_m1);
			pmh_pkg::S_UP_CMP: begin
				we = up_swap; // parent moves down into the hole
				wdata = rdata;
			end
			pmh_pkg::S_POP_RD: raddr = AW'(cnt_m1); // last entry
			pmh_pkg::S_DN_RDL: raddr = AW'(lc_m1);
			pmh_pkg::S_DN_RDR: raddr = AW'(lc);     // right child slot = lc
			pmh_pkg::S_DN_CMP: begin
				we = dn_swap; // winning child moves up into the hole
				wdata = best_val;
			end
			pmh_pkg::S_DONE: we = node_wr_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmh_pkg::S_IDLE;
			count_q <= '0;
			res_valid_q <= 1'b0;
			node_wr_q <= 1'b0;
			is_pop_q <= 1'b0;
			res_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == pmh_pkg::S_DONE) res_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				pmh_pkg::S_IDLE: if (acc) begin
					is_pop_q <= in_p.action == pmh_pkg::ACT_POP;
					node_wr_q <= push_ok;
					res_q <= acc_res;
					if (push_ok) count_q <= count_q + CW'(1);
				end
				pmh_pkg::S_POP_RD: begin
					res_q.has_entry <= 1'b1;
					res_q.out_priority <= rdata.prio;
					res_q.out_code <= rdata.code;
				end
				pmh_pkg::S_POP_WR: begin
					count_q <= cnt_m1;
					node_wr_q <= count_q > CW'(1);
				end
				pmh_pkg::S_DONE: res_q.now_empty <= count_q == '0;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pmh_pkg::S_IDLE: if (acc) begin
				node_q <= {in_p.entry_priority, in_p.entry_code};
				pos_q <= PW'(count_q + CW'(1));
			end
			pmh_pkg::S_UP_CMP: if (up_swap) pos_q <= par;
			pmh_pkg::S_POP_WR: begin
				node_q <= rdata; // last entry restarts at the root
				pos_q <= PW'(1);
			end
			pmh_pkg::S_DN_RDR: left_q <= rdata;
			pmh_pkg::S_DN_CMP: if (dn_swap) pos_q <= best_sel;
			default: ;
		endcase
	end

	assign busy = state_q != pmh_pkg::S_IDLE;
	assign out_stall = res_valid_q && !out_ch.ready;

	`PMH_ASSERT_NEVER(a_cnt_max, clk, arst_n, count_q > CW'(CAPACITY), "count overflow")
	`PMH_ASSERT_NEVER(a_busy_ready, clk, arst_n, busy && in_ch.ready, "ready while busy")
	`PMH_ASSERT_IMP(a_done_res, clk, arst_n, state_q == pmh_pkg::S_DONE |=> res_valid_q, "no result")
	`PMH_ASSERT_IMP(a_res_hold, clk, arst_n, out_stall |=> res_valid_q && $stable(res_q), "result moved")
endmodule
`default_nettype wire

// ===== tb/sv/priority_max_heap_test.sv =====
// Self-checking testbench for priority_max_heap: random push/pop/peek traffic
// checked against a behavioral heap. Depends on pmh_pkg, pmh_if and the RTL.
`timescale 1ns / 1ps
module priority_max_heap_test;
	// Transaction layouts, field order as listed for the channels
	typedef struct packed {
		pmh_pkg::action_t action;
		pmh_pkg::entry_t  entry;
	} heap_req_t;

	typedef struct packed {
		logic                      has_entry;
		logic [pmh_pkg::PrioW-1:0] out_priority;
		logic [pmh_pkg::CodeW-1:0] out_code;
		logic                      now_empty;
		pmh_pkg::status_t          op_status;
	} heap_rsp_t;

	localparam int unsigned DEPTH = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pmh_if #(.payload_t(heap_req_t)) req_bus ();
	pmh_if #(.payload_t(heap_rsp_t)) rsp_bus ();

	priority_max_heap #(.CAPACITY(DEPTH)) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (req_bus.sink),
		.out_ch(rsp_bus.source)
	);

	always #6 clk = ~clk;

	// Behavioral heap, slots 1-based
	pmh_pkg::entry_t heap_mirror [1:DEPTH];
	int unsigned     heap_fill = 0;

	heap_req_t   pending_ops [$];
	heap_rsp_t   awaited_rsp [$];
	int unsigned error_count = 0;
	int unsigned rsp_seen = 0;
	int unsigned n_push = 0, n_pop = 0, n_peek = 0, n_full = 0, n_empty = 0;

	function automatic bit outranks(pmh_pkg::entry_t a, pmh_pkg::entry_t b);
		if (a.prio == b.prio) return a.code < b.code;
		return a.prio > b.prio;
	endfunction

	function automatic void swap_slots(int unsigned x, int unsigned y);
		pmh_pkg::entry_t t;
		t = heap_mirror[x];
		heap_mirror[x] = heap_mirror[y];
		heap_mirror[y] = t;
	endfunction

	// Apply one operation to the mirror and return the response it should give
	function automatic heap_rsp_t heap_apply(heap_req_t op);
		heap_rsp_t   r;
		int unsigned pos, best, lc;
		r = '0;
		r.op_status = pmh_pkg::ST_OK;
		case (op.action)
			pmh_pkg::ACT_PUSH: begin
				if (heap_fill >= DEPTH) begin
					r.op_status = pmh_pkg::ST_FULL;
				end else begin
					heap_fill++;
					heap_mirror[heap_fill] = op.entry;
					pos = heap_fill;
					while (pos > 1) begin
						if (outranks(heap_mirror[pos], heap_mirror[pos >> 1]))
							swap_slots(pos, pos >> 1);
						pos = pos >> 1;
					end
				end
			end
			pmh_pkg::ACT_POP, pmh_pkg::ACT_PEEK: begin
				if (heap_fill == 0) begin
					r.op_status = pmh_pkg::ST_EMPTY;
				end else begin
					r.has_entry = 1'b1;
					r.out_priority = heap_mirror[1].prio;
					r.out_code = heap_mirror[1].code;
					if (op.action == pmh_pkg::ACT_POP) begin
						swap_slots(1, heap_fill);
						heap_fill--;
						pos = 1;
						forever begin
							best = pos;
							lc = pos << 1;
							if (lc <= heap_fill && outranks(heap_mirror[lc], heap_mirror[best]))
								best = lc;
							if (lc + 1 <= heap_fill
									&& outranks(heap_mirror[lc + 1], heap_mirror[best]))
								best = lc + 1;
							if (best == pos) break;
							swap_slots(best, pos);
							pos = best;
						end
					end
				end
			end
			default: ;
		endcase
		r.now_empty = (heap_fill == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Idle gaps: mostly none or short, a few long; bursts with no gaps at all
	bit burst_mode = 1'b0;
	always @(posedge clk) if ($urandom_range(0, 99) == 0) burst_mode <= ~burst_mode;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver
	int unsigned drv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		heap_req_t nxt;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.payload <= '0;
			drv_gap = 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				case (req_bus.payload.action)
					pmh_pkg::ACT_PUSH: n_push++;
					pmh_pkg::ACT_POP:  n_pop++;
					pmh_pkg::ACT_PEEK: n_peek++;
					default: ;
				endcase
				awaited_rsp.push_back(heap_apply(req_bus.payload));
				drv_gap = pick_gap();
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (drv_gap == 0 && pending_ops.size() > 0) begin
					nxt = pending_ops.pop_front();
					req_bus.payload <= nxt;
					req_bus.valid <= 1'b1;
				end else begin
					if (drv_gap > 0) drv_gap--;
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and checker
	int unsigned mon_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		heap_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			mon_gap = 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				rsp_seen++;
				if (awaited_rsp.size() == 0) begin
					report_mismatch("unexpected response", rsp_seen, 0);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp_bus.payload.op_status == pmh_pkg::ST_FULL) n_full++;
					if (rsp_bus.payload.op_status == pmh_pkg::ST_EMPTY) n_empty++;
					if (rsp_bus.payload.has_entry !== want.has_entry)
						report_mismatch("has_entry", 32'(rsp_bus.payload.has_entry),
							32'(want.has_entry));
					if (rsp_bus.payload.out_priority !== want.out_priority)
						report_mismatch("out_priority", 32'(rsp_bus.payload.out_priority),
							32'(want.out_priority));
					if (rsp_bus.payload.out_code !== want.out_code)
						report_mismatch("out_code", 32'(rsp_bus.payload.out_code),
							32'(want.out_code));
					if (rsp_bus.payload.now_empty !== want.now_empty)
						report_mismatch("now_empty", 32'(rsp_bus.payload.now_empty),
							32'(want.now_empty));
					if (rsp_bus.payload.op_status !== want.op_status)
						report_mismatch("op_status", 32'(rsp_bus.payload.op_status),
							32'(want.op_status));
				end
				mon_gap = pick_gap();
			end
			if (mon_gap > 0) begin
				mon_gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	function automatic heap_req_t make_op(pmh_pkg::action_t a, int unsigned p, int unsigned c);
		heap_req_t op;
		op.action = a;
		op.entry.prio = 16'(p);
		op.entry.code = 16'(c);
		return op;
	endfunction

	// Values clustered so that equal priorities and equal codes are common
	function automatic int unsigned pick_field();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3) return $urandom_range(0, 3);
		if (r < 4) return 16'hFFFF - $urandom_range(0, 2);
		return $urandom_range(0, 16'hFFFF);
	endfunction

	// Stimulus
	initial begin
		int unsigned push_pct, left;
		// empty-heap cases and the unused action
		pending_ops.push_back(make_op(pmh_pkg::ACT_PEEK, 0, 0));
		pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 16'hFFFF, 16'hFFFF));
		pending_ops.push_back(make_op(pmh_pkg::ACT_NONE, 16'h5A5A, 16'hA5A5));
		// field extremes and priority ties, smaller code should win
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h0000, 16'h0000));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'hFFFF, 16'hFFFF));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'hFFFF, 16'h0001));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h8000, 16'h7FFF));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h8000, 16'h7FFE));
		pending_ops.push_back(make_op(pmh_pkg::ACT_NONE, 0, 0));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PEEK, 0, 0));
		// equal children under the root, popped back in turn
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h0000, 16'h0000));
		for (int i = 0; i < 7; i++)
			pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 0, 0));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h0010, 16'h0005));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h0010, 16'h0005));
		pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, 16'h0010, 16'h0005));
		pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 0, 0));
		pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 0, 0));
		pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 0, 0));

		// random phases; the push share swings so the heap fills, overflows and drains
		left = 920;
		while (left > 0) begin
			case ($urandom_range(0, 3))
				0: push_pct = 90;
				1: push_pct = 55;
				2: push_pct = 45;
				default: push_pct = 15;
			endcase
			for (int i = 0; i < 90 && left > 0; i++) begin
				if ($urandom_range(0, 49) == 0) begin
					pending_ops.push_back(make_op(pmh_pkg::ACT_NONE, $urandom, $urandom));
				end else begin
					if ($urandom_range(1, 100) <= push_pct)
						pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, pick_field(),
							pick_field()));
					else if ($urandom_range(0, 3) == 0)
						pending_ops.push_back(make_op(pmh_pkg::ACT_PEEK, $urandom, $urandom));
					else
						pending_ops.push_back(make_op(pmh_pkg::ACT_POP, $urandom, $urandom));
					left--;
				end
			end
		end
		// make sure overflow on a full heap is seen, then drain past empty
		for (int i = 0; i < DEPTH + 3; i++)
			pending_ops.push_back(make_op(pmh_pkg::ACT_PUSH, pick_field(), pick_field()));
		for (int i = 0; i < DEPTH + 3; i++)
			pending_ops.push_back(make_op(pmh_pkg::ACT_POP, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 0 || req_bus.valid || awaited_rsp.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d push, %0d pop, %0d peek; %0d responses checked",
			n_push, n_pop, n_peek, rsp_seen);
		$display("full-heap drops %0d, empty-heap reads %0d", n_full, n_empty);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("timeout with %0d responses outstanding", awaited_rsp.size());
		$display("status: fail");
		$finish;
	end
endmodule
